// ===== sv/fvc_pkg.sv =====
// ----------------------------------------------------------------------------
// fvc_pkg: shared types and constants for the frame validator
// Status codes, configuration register indexes, reset values and the
// byte-wide CRC-16 (polynomial 0x1021, MSB first) update.
// ----------------------------------------------------------------------------
package fvc_pkg;

  // Frame length at which further bytes mark the frame overlong
  localparam logic [7:0] MaxFrameLen = 8'd255;

  // CRC-16 constants
  localparam logic [15:0] CrcPoly = 16'h1021;
  localparam logic [15:0] CrcTop  = 16'h8000;

  // Configuration reset values
  localparam logic [7:0] StartMarkRst = 8'd126;
  localparam logic [7:0] EndMarkRst   = 8'd127;
  localparam logic [7:0] ModAddrRst   = 8'd0;
  localparam logic [7:0] MinLenRst    = 8'd8;
  localparam logic [7:0] OwnIdRst     = 8'd0;
  localparam logic [7:0] QueryIdRst   = 8'd0;
  localparam logic [7:0] MasterIdRst  = 8'd0;

  // Width of the packed result transaction
  localparam int unsigned OutDataW = 40;

  typedef enum logic [2:0] {
    CfgStartMark = 3'd0,
    CfgEndMark   = 3'd1,
    CfgModAddr   = 3'd2,
    CfgMinLen    = 3'd3,
    CfgOwnId     = 3'd4,
    CfgQueryId   = 3'd5,
    CfgMasterId  = 3'd6
  } cfg_idx_e;

  typedef enum logic [3:0] {
    StOk       = 4'd0,
    StForward  = 4'd1,
    StShort    = 4'd2,
    StStart    = 4'd3,
    StEnd      = 4'd4,
    StModule   = 4'd5,
    StCrc      = 4'd6,
    StId       = 4'd7,
    StOverlong = 4'd8
  } status_e;

  typedef struct packed {
    logic [7:0] start_mark;
    logic [7:0] end_mark;
    logic [7:0] module_address;
    logic [7:0] min_frame_length;
    logic [7:0] own_id;
    logic [7:0] query_id;
    logic [7:0] master_id;
  } cfg_t;

  typedef struct packed {
    status_e     status;
    logic [7:0]  received_id;
    logic [7:0]  frame_length;
    logic [15:0] computed_crc;
  } result_t;

  // Fold one byte into the CRC, MSB first
  function automatic logic [15:0] crc_fold(logic [15:0] crc_in, logic [7:0] data);
    logic [15:0] crc;
    crc = crc_in ^ {data, 8'h00};
    for (int k = 0; k < 8; k++) begin
      if ((crc & CrcTop) != 16'h0000) begin
        crc = {crc[14:0], 1'b0} ^ CrcPoly;
      end else begin
        crc = {crc[14:0], 1'b0};
      end
    end
    return crc;
  endfunction

endpackage

// ===== sv/fvc_core.sv =====
// ----------------------------------------------------------------------------
// fvc_core: per-frame state and frame judgment
// Tracks byte position, header bytes, the trailing three-byte delay line
// and the running CRC; produces the frame status on the closing byte.
// ----------------------------------------------------------------------------
module fvc_core import fvc_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       step_i,      // consume one byte this cycle
  input  logic [7:0] byte_i,
  input  logic       last_i,
  input  cfg_t       cfg_i,
  output result_t    result_o     // valid on a step with last_i set
);

  logic [7:0]  count_q, count_d;
  logic [15:0] crc_q, crc_d;
  logic [7:0]  tail_q [3];
  logic [7:0]  first_q, first_d;
  logic [7:0]  module_q, module_d;
  logic [7:0]  id_q, id_d;
  logic        overlong_q, overlong_d;
  logic [7:0]  frame_len;
  logic [15:0] saved_crc;
  status_e     status;

  // Capture header bytes and fold the byte leaving the delay line
  always_comb begin
    overlong_d = overlong_q | (count_q >= MaxFrameLen);
    first_d    = (count_q == 8'd0) ? byte_i : first_q;
    module_d   = (count_q == 8'd1) ? byte_i : module_q;
    id_d       = (count_q == 8'd2) ? byte_i : id_q;
    crc_d      = (count_q >= 8'd4) ? crc_fold(crc_q, tail_q[2]) : crc_q;
    count_d    = count_q + {7'd0, (count_q != 8'hFF)};
  end

  // Judge the frame in priority order
  always_comb begin
    frame_len = count_d;
    saved_crc = {tail_q[0], tail_q[1]};
    if (overlong_d) begin
      status = StOverlong;
    end else if (frame_len <= cfg_i.min_frame_length) begin
      status = StShort;
    end else if (first_d != cfg_i.start_mark) begin
      status = StStart;
    end else if (byte_i != cfg_i.end_mark) begin
      status = StEnd;
    end else if (module_d != cfg_i.module_address) begin
      status = StModule;
    end else if (crc_d != saved_crc) begin
      status = StCrc;
    end else if ((id_d == cfg_i.own_id) || (id_d == cfg_i.query_id)) begin
      status = StOk;
    end else if (cfg_i.own_id == cfg_i.master_id) begin
      status = StForward;
    end else begin
      status = StId;
    end
    result_o.status       = status;
    result_o.received_id  = id_d;
    result_o.frame_length = frame_len;
    result_o.computed_crc = crc_d;
  end

  // Advance frame state; clear it when the frame closes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q    <= 8'd0;
      crc_q      <= 16'd0;
      tail_q[0]  <= 8'd0;
      tail_q[1]  <= 8'd0;
      tail_q[2]  <= 8'd0;
      first_q    <= 8'd0;
      module_q   <= 8'd0;
      id_q       <= 8'd0;
      overlong_q <= 1'b0;
    end else if (step_i) begin
      if (last_i) begin
        count_q    <= 8'd0;
        crc_q      <= 16'd0;
        tail_q[0]  <= 8'd0;
        tail_q[1]  <= 8'd0;
        tail_q[2]  <= 8'd0;
        first_q    <= 8'd0;
        module_q   <= 8'd0;
        id_q       <= 8'd0;
        overlong_q <= 1'b0;
      end else begin
        count_q    <= count_d;
        crc_q      <= crc_d;
        tail_q[0]  <= byte_i;
        tail_q[1]  <= tail_q[0];
        tail_q[2]  <= tail_q[1];
        first_q    <= first_d;
        module_q   <= module_d;
        id_q       <= id_d;
        overlong_q <= overlong_d;
      end
    end
  end

endmodule

// ===== sv/frame_validator_crc16.sv =====
// Status tvalid rises once the last byte has passed the input register and loaded the output register.
// Throughput: one byte per cycle, subject to the stall below; the byte-wide CRC fold sits in one stage.
// A status waiting in the output register does not block later bytes
// unless the closing byte of the next frame reaches it first.
// Reset (rst_ni low, asynchronous) clears frame state, empties both
// registers and restores configuration defaults.
// ----------------------------------------------------------------------------
// frame_validator_crc16: streaming frame checker with CRC-16
// Validates framing, module address, CRC-16/XMODEM and unit id of each
// received frame and emits one status transaction per frame.
// ----------------------------------------------------------------------------
module frame_validator_crc16 import fvc_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  // Byte input
  input  logic                s_axis_tvalid_i,
  output logic                s_axis_tready_o,
  input  logic [7:0]          s_axis_tdata_i,   // [7:0] data_byte
  input  logic                s_axis_tlast_i,   // last_byte
  // Status output
  output logic                m_axis_tvalid_o,
  input  logic                m_axis_tready_i,
  // [3:0] status, [11:4] received_id, [19:12] frame_length,
  // [35:20] computed_crc, [39:36] zero
  output logic [OutDataW-1:0] m_axis_tdata_o,
  // Configuration writes
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [2:0]          cfg_index_i,
  input  logic [7:0]          cfg_data_i
);

  cfg_t                cfg_q;
  logic                in_valid_q, in_valid_d;
  logic [7:0]          in_byte_q;
  logic                in_last_q;
  logic                s_accept;
  logic                step;
  result_t             result;
  logic                out_valid_q;
  logic [OutDataW-1:0] out_data_q;

  assign cfg_ready_o = 1'b1;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.start_mark       <= StartMarkRst;
      cfg_q.end_mark         <= EndMarkRst;
      cfg_q.module_address   <= ModAddrRst;
      cfg_q.min_frame_length <= MinLenRst;
      cfg_q.own_id           <= OwnIdRst;
      cfg_q.query_id         <= QueryIdRst;
      cfg_q.master_id        <= MasterIdRst;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CfgStartMark: cfg_q.start_mark       <= cfg_data_i;
        CfgEndMark:   cfg_q.end_mark         <= cfg_data_i;
        CfgModAddr:   cfg_q.module_address   <= cfg_data_i;
        CfgMinLen:    cfg_q.min_frame_length <= cfg_data_i;
        CfgOwnId:     cfg_q.own_id           <= cfg_data_i;
        CfgQueryId:   cfg_q.query_id         <= cfg_data_i;
        CfgMasterId:  cfg_q.master_id        <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Input stage: drain a byte unless it closes a frame and the output is full
  assign step            = in_valid_q && (!in_last_q || !out_valid_q || m_axis_tready_i);
  assign s_axis_tready_o = !in_valid_q || step;
  assign s_accept        = s_axis_tvalid_i && s_axis_tready_o;

  always_comb begin
    in_valid_d = in_valid_q;
    if (s_accept) begin
      in_valid_d = 1'b1;
    end else if (step) begin
      in_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= in_valid_d;
    end
  end

  // Hold the byte payload
  always_ff @(posedge clk_i) begin
    if (s_accept) begin
      in_byte_q <= s_axis_tdata_i;
      in_last_q <= s_axis_tlast_i;
    end
  end

  fvc_core u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (step),
    .byte_i   (in_byte_q),
    .last_i   (in_last_q),
    .cfg_i    (cfg_q),
    .result_o (result)
  );

  // Output register: load on a closing byte, drop when taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (step && in_last_q) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step && in_last_q) begin
      out_data_q <= {4'd0, result.computed_crc, result.frame_length,
                     result.received_id, result.status};
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;

endmodule

// ===== sv/fvc_checker.sv =====
// ----------------------------------------------------------------------------
// fvc_port_checker: port-level assertions for the frame validator
// Checks output hold under stall, reset behavior and consistency of the
// status fields; bound to the top level.
// ----------------------------------------------------------------------------
module fvc_port_checker import fvc_pkg::*; (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                m_axis_tvalid_o,
  input logic                m_axis_tready_i,
  input logic [OutDataW-1:0] m_axis_tdata_o
);

  // Stalled result transaction holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o))
    else $error("result changed while stalled");

  // No result in the cycle after reset is sampled low
  assert property (@(posedge clk_i) !rst_ni |=> !m_axis_tvalid_o)
    else $error("result valid during reset");

  // Every reported frame holds at least one byte and a known status
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (m_axis_tdata_o[19:12] != 8'd0) && (m_axis_tdata_o[3:0] <= 4'd8))
    else $error("bad frame length or status code");

  // Overlong status only after the length limit
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && (m_axis_tdata_o[3:0] == StOverlong) |->
      m_axis_tdata_o[19:12] >= MaxFrameLen)
    else $error("overlong status on a short frame");

  // Frames of four bytes or fewer cover no CRC bytes
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && (m_axis_tdata_o[19:12] <= 8'd4) |-> m_axis_tdata_o[35:20] == 16'd0)
    else $error("nonzero CRC on a frame without payload");

endmodule

bind frame_validator_crc16 fvc_port_checker u_fvc_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o)
);
